### rtl/hsv_to_rgb_converter_defines.svh
// Assertion macros shared by the HSV to RGB converter RTL.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define HSV2RGB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("hsv2rgb assertion failed");

// Check that cons holds in the cycle after ante.
`define HSV2RGB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("hsv2rgb assertion failed");

`else

`define HSV2RGB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HSV2RGB_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/hsv2rgb_pkg.sv
// Types and constants shared by the HSV to RGB converter.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

	// Field widths
	localparam int HUE_W  = 16;
	localparam int UNIT_W = 9;
	localparam int FRAC_W = 17;   // fractions in units of 2^-16, up to 1.0 inclusive
	localparam int CHAN_W = 8;
	localparam int REM_W  = 10;   // position inside one sextant, 0..960
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 24;

	// Angle and unit constants
	localparam int HUE_TURN    = 5760;   // 360 degrees in 1/16 degree
	localparam int HUE_SEXTANT = 960;    // 60 degrees in 1/16 degree
	localparam int HUE_BIAS    = 6 * HUE_TURN;
	localparam int UNIT_ONE    = 256;
	localparam int CHAN_MAX    = 255;

	// Reciprocal multipliers for division by constants
	localparam int DIV15_MUL_HUE   = 4370;      // floor(n/15), n < 4681
	localparam int DIV15_SHIFT_HUE = 16;
	localparam int DIV6_MUL        = 43;        // floor(n/6), n < 128
	localparam int DIV6_SHIFT      = 8;
	localparam int DIV15_MUL_X     = 1118482;   // floor(n/15), n < 2^20
	localparam int DIV15_SHIFT_X   = 24;

	// Sextant of the wrapped hue, named by the channel order of chroma and secondary
	typedef enum logic [2:0] {
		SEXT_RED_GRN = 3'd0,   // (c, x, 0)
		SEXT_GRN_RED = 3'd1,   // (x, c, 0)
		SEXT_GRN_BLU = 3'd2,   // (0, c, x)
		SEXT_BLU_GRN = 3'd3,   // (0, x, c)
		SEXT_BLU_RED = 3'd4,   // (x, 0, c)
		SEXT_RED_BLU = 3'd5    // (c, 0, x)
	} sext_t;

endpackage

### rtl/hsv2rgb_chan.sv
// Scale of one channel fraction to an 8-bit intensity with cap.
`timescale 1ns / 1ps

module hsv2rgb_chan (
	input  logic [hsv2rgb_pkg::FRAC_W-1:0] comp,
	input  logic [hsv2rgb_pkg::FRAC_W-1:0] ofs,
	output logic [hsv2rgb_pkg::CHAN_W-1:0] level
);

	localparam int SUM_W  = hsv2rgb_pkg::FRAC_W + 1;
	localparam int PROD_W = SUM_W + hsv2rgb_pkg::CHAN_W;

	logic [SUM_W-1:0]  sum;
	logic [PROD_W-1:0] scaled;
	logic [PROD_W-17:0] whole;

	// Add offset, multiply by 255 as a shift and subtract, keep the integer part capped at 255
	always_comb begin
		sum    = SUM_W'(comp) + SUM_W'(ofs);
		scaled = {sum, {hsv2rgb_pkg::CHAN_W{1'b0}}} - PROD_W'(sum);
		whole  = scaled[PROD_W-1:16];
		if (whole > (PROD_W-16)'(hsv2rgb_pkg::CHAN_MAX)) begin
			level = hsv2rgb_pkg::CHAN_W'(hsv2rgb_pkg::CHAN_MAX);
		end else begin
			level = whole[hsv2rgb_pkg::CHAN_W-1:0];
		end
	end

endmodule

### rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter top level: six-stage pipeline from hue, saturation, value to RGB.
//
//  channel | direction | tdata fields (low bit up)               | width
//  s_axis  | in        | hue[15:0] sat[24:16] val[33:25] zero pad | 40
//  m_axis  | out       | red[7:0] green[15:8] blue[23:16]         | 24
//
// One transaction is accepted per cycle while the output is not stalled; the six
// register stages only set the latency, the middle ones each holding a small multiply
// or two (sextant count and chroma, sextant remainder, secondary product, divide by 960).
// arst_n clears all valid bits; payload registers are not reset.
// A stall on m_tready freezes every stage at once, and s_tready drops with it.
`timescale 1ns / 1ps
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,    // hue[15:0], sat[24:16], val[33:25], zeros above
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata     // red[7:0], green[15:8], blue[23:16]
);

	localparam int FW = hsv2rgb_pkg::FRAC_W;
	localparam int UW = hsv2rgb_pkg::UNIT_W;
	localparam int RW = hsv2rgb_pkg::REM_W;
	localparam int KW = 7;    // sextant count of the biased hue, up to 70
	localparam int PW = FW + RW;

	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [FW-1:0] u_s1, u_s2;
	logic [UW-1:0] sat_s1, val_s1, val_s2;
	logic [KW-1:0] k_s2;
	logic [FW-1:0] c_s2, c_s3, c_s4, c_s5;
	logic [FW-1:0] m_s3, m_s4, m_s5;
	logic [RW-1:0] f_s3;
	hsv2rgb_pkg::sext_t sext_s3, sext_s4, sext_s5;
	logic [PW-1:0] prod_s4;
	logic [FW-1:0] x_s5;
	logic [23:0]   rgb_s6;

	// Stage 1 inputs
	logic [UW-1:0] sat_in, val_in, sat_cl, val_cl;
	logic [FW-1:0] u_in;

	// Stage 2 inputs
	logic [23:0]        kp;
	logic [2*UW-1:0]    cp;

	// Stage 3 inputs
	logic [FW-1:0]      km;
	logic [FW-1:0]      rem_full;
	logic [RW-1:0]      rem;
	logic [KW+5:0]      jp;
	logic [KW-1:0]      kmod;
	logic [FW-1:0]      vs;

	// Stage 5 inputs
	logic [19:0]        n2;
	logic [40:0]        xp;

	// Stage 6 inputs
	logic [FW-1:0]      rc, gc, bc;
	logic [7:0]         red, green, blue;

	// Advance the whole pipeline unless the output transaction is stalled
	assign adv      = !v_s6 || m_tready;
	assign s_tready = adv;
	assign m_tvalid = v_s6;
	assign m_tdata  = rgb_s6;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: bias hue by six turns, clamp saturation and value to one
	always_comb begin
		sat_in = s_tdata[24:16];
		val_in = s_tdata[33:25];
		u_in   = {s_tdata[15], s_tdata[15:0]} + FW'(hsv2rgb_pkg::HUE_BIAS);
		sat_cl = (sat_in > UW'(hsv2rgb_pkg::UNIT_ONE)) ? UW'(hsv2rgb_pkg::UNIT_ONE) : sat_in;
		val_cl = (val_in > UW'(hsv2rgb_pkg::UNIT_ONE)) ? UW'(hsv2rgb_pkg::UNIT_ONE) : val_in;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1   <= u_in;
			sat_s1 <= sat_cl;
			val_s1 <= val_cl;
		end
	end

	// Stage 2: count whole sextants of the biased hue, form chroma
	always_comb begin
		kp = 24'(u_s1[FW-1:6]) * 24'(hsv2rgb_pkg::DIV15_MUL_HUE);
		cp = val_s1 * sat_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s2   <= kp[hsv2rgb_pkg::DIV15_SHIFT_HUE +: KW];
			c_s2   <= cp[FW-1:0];
			u_s2   <= u_s1;
			val_s2 <= val_s1;
		end
	end

	// Stage 3: remainder inside the sextant, sextant index, triangle factor, offset
	always_comb begin
		km       = FW'(k_s2) * FW'(hsv2rgb_pkg::HUE_SEXTANT);
		rem_full = u_s2 - km;
		rem      = rem_full[RW-1:0];
		jp       = (KW+6)'(k_s2) * (KW+6)'(hsv2rgb_pkg::DIV6_MUL);
		kmod     = k_s2 - KW'(6 * jp[KW+5:hsv2rgb_pkg::DIV6_SHIFT]);
		vs       = {val_s2, 8'd0};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sext_s3 <= hsv2rgb_pkg::sext_t'(kmod[2:0]);
			f_s3    <= kmod[0] ? RW'(hsv2rgb_pkg::HUE_SEXTANT) - rem : rem;
			c_s3    <= c_s2;
			m_s3    <= vs - c_s2;
		end
	end

	// Stage 4: chroma times triangle factor
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s4 <= PW'(c_s3) * PW'(f_s3);
			c_s4    <= c_s3;
			m_s4    <= m_s3;
			sext_s4 <= sext_s3;
		end
	end

	// Stage 5: divide the product by 960 as a shift and a reciprocal multiply
	always_comb begin
		n2 = prod_s4[25:6];
		xp = 41'(n2) * 41'(hsv2rgb_pkg::DIV15_MUL_X);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s5    <= xp[hsv2rgb_pkg::DIV15_SHIFT_X +: FW];
			c_s5    <= c_s4;
			m_s5    <= m_s4;
			sext_s5 <= sext_s4;
		end
	end

	// Stage 6: place chroma and secondary by sextant
	always_comb begin
		rc = '0;
		gc = '0;
		bc = '0;
		case (sext_s5)
			hsv2rgb_pkg::SEXT_RED_GRN: begin
				rc = c_s5;
				gc = x_s5;
			end
			hsv2rgb_pkg::SEXT_GRN_RED: begin
				rc = x_s5;
				gc = c_s5;
			end
			hsv2rgb_pkg::SEXT_GRN_BLU: begin
				gc = c_s5;
				bc = x_s5;
			end
			hsv2rgb_pkg::SEXT_BLU_GRN: begin
				gc = x_s5;
				bc = c_s5;
			end
			hsv2rgb_pkg::SEXT_BLU_RED: begin
				rc = x_s5;
				bc = c_s5;
			end
			hsv2rgb_pkg::SEXT_RED_BLU: begin
				rc = c_s5;
				bc = x_s5;
			end
			default: begin
				rc = '0;
				gc = '0;
				bc = '0;
			end
		endcase
	end

	hsv2rgb_chan u_chan_red (
		.comp  (rc),
		.ofs   (m_s5),
		.level (red)
	);

	hsv2rgb_chan u_chan_green (
		.comp  (gc),
		.ofs   (m_s5),
		.level (green)
	);

	hsv2rgb_chan u_chan_blue (
		.comp  (bc),
		.ofs   (m_s5),
		.level (blue)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s6 <= {blue, green, red};
		end
	end

	// Secondary never exceeds chroma
	`HSV2RGB_ASSERT_IMP(a_x_le_c, clk, arst_n, v_s5, x_s5 <= c_s5)

	// Triangle factor stays within one sextant
	`HSV2RGB_ASSERT_IMP(a_f_range, clk, arst_n, v_s3, f_s3 <= RW'(hsv2rgb_pkg::HUE_SEXTANT))

	// Chroma plus offset equals value, never above one
	`HSV2RGB_ASSERT_IMP(a_cm_sum, clk, arst_n, v_s3, (FW+1)'(c_s3) + (FW+1)'(m_s3) <= (FW+1)'(65536))

	// A stall holds stage 5 valid with its secondary and sextant unchanged
	`HSV2RGB_ASSERT_NXT(a_stall_hold, clk, arst_n, !adv && v_s5, v_s5 && $stable(x_s5) && $stable(sext_s5))

endmodule
